[hw/rtl/btn_rpt_pkg.sv]
// Shared types and constants for the button edge and auto-repeat block.
`timescale 1ns / 1ps
package btn_rpt_pkg;

  localparam int TIME_W     = 40;
  localparam int MASK_W     = 16;
  localparam int CFG_W      = 16;
  localparam int FIFO_DEPTH = 2;

  localparam logic [CFG_W-1:0] DELAY_RST = 16'd500;
  localparam logic [CFG_W-1:0] IVL_RST   = 16'd100;

  localparam logic REG_DELAY    = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SAMPLE,
    OP_QUERY,
    OP_NULL_QUERY
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_SCAN,
    BK_CHECK,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        player;
    logic [TIME_W-1:0] now;
    logic [MASK_W-1:0] mask;
  } cmd_t;

  typedef struct packed {
    logic              all_held;
    logic              any_held;
    logic              all_just_pressed;
    logic              all_just_released;
    logic              any_just_pressed;
    logic              repeat_fire;
    logic [MASK_W-1:0] held_buttons;
    logic [MASK_W-1:0] previous_buttons;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num_a;
    logic [TIME_W-1:0] num_b;
    logic [CFG_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic differ;
  } div_rsp_t;

endpackage

[hw/rtl/btn_rpt_front.sv]
// Front end: classifies incoming items into commands for the back end.
`timescale 1ns / 1ps
module btn_rpt_front #(
  parameter int PLAYERS = 4,
  parameter int BUTTONS = 16
) (
  input  logic                             accept,
  input  logic [1:0]                       in_kind,
  input  logic [1:0]                       in_player,
  input  logic [btn_rpt_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [btn_rpt_pkg::MASK_W-1:0]   in_new_buttons,
  input  logic [btn_rpt_pkg::MASK_W-1:0]   in_query_mask,
  output logic                             cmd_push,
  output btn_rpt_pkg::cmd_t                cmd
);

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [btn_rpt_pkg::MASK_W-1:0] BTN_MASK =
    btn_rpt_pkg::MASK_W'((32'd1 << BUTTONS) - 32'd1);

  logic player_ok;
  logic keep;

  assign player_ok = (32'(in_player) < PLAYERS);
  assign cmd_push  = accept && keep;

  always_comb begin
    keep       = 1'b0;
    cmd.op     = btn_rpt_pkg::OP_TICK;
    cmd.player = in_player;
    cmd.now    = in_now_ms;
    cmd.mask   = in_query_mask;
    unique case (in_kind)
      KIND_TICK: begin
        keep = 1'b1;
      end
      KIND_SAMPLE: begin
        keep     = player_ok;
        cmd.op   = btn_rpt_pkg::OP_SAMPLE;
        cmd.mask = in_new_buttons & BTN_MASK;
      end
      KIND_QUERY: begin
        keep   = 1'b1;
        cmd.op = player_ok ? btn_rpt_pkg::OP_QUERY : btn_rpt_pkg::OP_NULL_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/btn_rpt_fifo.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module btn_rpt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  btn_rpt_pkg::cmd_t wr_data,
  input  logic              rd_en,
  output btn_rpt_pkg::cmd_t rd_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (btn_rpt_pkg::FIFO_DEPTH > 1) ? $clog2(btn_rpt_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(btn_rpt_pkg::FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(btn_rpt_pkg::FIFO_DEPTH - 1);

  btn_rpt_pkg::cmd_t entry_r [btn_rpt_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(btn_rpt_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/btn_rpt_div.sv]
// Bit-serial dual divider that reports whether two quotients by one divisor differ.
`timescale 1ns / 1ps
module btn_rpt_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  btn_rpt_pkg::div_req_t req,
  output btn_rpt_pkg::div_rsp_t rsp
);

  localparam int TW    = btn_rpt_pkg::TIME_W;
  localparam int DW    = btn_rpt_pkg::CFG_W;
  localparam int CNT_W = $clog2(TW);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TW - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             diff_r, diff_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0]    num_a_r, num_a_nxt;
  logic [TW-1:0]    num_b_r, num_b_nxt;
  logic [DW-1:0]    rem_a_r, rem_a_nxt;
  logic [DW-1:0]    rem_b_r, rem_b_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW:0]      part_a, part_b;
  logic             qa, qb;

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.differ = diff_r;

  always_comb begin
    part_a    = {rem_a_r, num_a_r[TW-1]};
    part_b    = {rem_b_r, num_b_r[TW-1]};
    qa        = (part_a >= {1'b0, den_r});
    qb        = (part_b >= {1'b0, den_r});
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    diff_nxt  = diff_r;
    cnt_nxt   = cnt_r;
    num_a_nxt = num_a_r;
    num_b_nxt = num_b_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    den_nxt   = den_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      diff_nxt  = 1'b0;
      cnt_nxt   = '0;
      num_a_nxt = req.num_a;
      num_b_nxt = req.num_b;
      rem_a_nxt = '0;
      rem_b_nxt = '0;
      den_nxt   = req.den;
    end else if (busy_r) begin
      rem_a_nxt = qa ? DW'(part_a - {1'b0, den_r}) : DW'(part_a);
      rem_b_nxt = qb ? DW'(part_b - {1'b0, den_r}) : DW'(part_b);
      num_a_nxt = {num_a_r[TW-2:0], 1'b0};
      num_b_nxt = {num_b_r[TW-2:0], 1'b0};
      diff_nxt  = diff_r || (qa != qb);
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r  <= diff_nxt;
    cnt_r   <= cnt_nxt;
    num_a_r <= num_a_nxt;
    num_b_r <= num_b_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    den_r   <= den_nxt;
  end

endmodule

[hw/rtl/btn_rpt_back.sv]
// Back end: executes ticks, samples and queries and holds the result register.
`timescale 1ns / 1ps
module btn_rpt_back #(
  parameter int PLAYERS = 4,
  parameter int BUTTONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  btn_rpt_pkg::cmd_t             q_cmd,
  output logic                          q_pop,
  input  logic [btn_rpt_pkg::CFG_W-1:0] delay,
  input  logic [btn_rpt_pkg::CFG_W-1:0] interval,
  output btn_rpt_pkg::div_req_t         div_req,
  input  btn_rpt_pkg::div_rsp_t         div_rsp,
  input  logic                          out_pop,
  output logic                          out_vld,
  output btn_rpt_pkg::res_t             out_res,
  output logic                          res_load
);

  localparam int TW     = btn_rpt_pkg::TIME_W;
  localparam int MW     = btn_rpt_pkg::MASK_W;
  localparam int PIDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int DEPTH  = PLAYERS * BUTTONS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW     = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [BW-1:0] LAST_B = BW'(BUTTONS - 1);

  btn_rpt_pkg::bk_state_t state_r, state_nxt;
  logic [TW-1:0]      cur_r, cur_nxt;
  logic [TW-1:0]      prev_r, prev_nxt;
  logic [MW-1:0]      held_r [PLAYERS];
  logic [MW-1:0]      held_nxt [PLAYERS];
  logic [MW-1:0]      prior_r [PLAYERS];
  logic [MW-1:0]      prior_nxt [PLAYERS];
  logic [PIDX_W-1:0]  pl_r, pl_nxt;
  logic [BUTTONS-1:0] scan_r, scan_nxt;
  logic [BW-1:0]      b_r, b_nxt;
  btn_rpt_pkg::res_t  wk_r, wk_nxt;
  btn_rpt_pkg::res_t  res_r, res_nxt;
  logic               out_vld_r, out_vld_nxt;

  logic [TW-1:0]      mem [DEPTH];
  logic               vld_r [DEPTH];
  logic [TW-1:0]      rd_data_r;
  logic               rd_vld_r;
  logic               mem_we, mem_re;
  logic [AW-1:0]      addr;

  logic [PIDX_W-1:0]  pidx;
  logic [MW-1:0]      h, p, m, sel16;
  logic [TW:0]        cur_x, prev_x, first;
  logic [TW-1:0]      press;
  logic [btn_rpt_pkg::CFG_W-1:0] step;

  assign out_vld = out_vld_r;
  assign out_res = res_r;
  assign addr    = AW'(32'(pl_r) * BUTTONS + 32'(b_r));
  assign pidx    = PIDX_W'(q_cmd.player);
  assign press   = rd_vld_r ? rd_data_r : '0;
  assign cur_x   = {1'b0, cur_r};
  assign prev_x  = {1'b0, prev_r};
  assign first   = {1'b0, press} + (TW + 1)'(delay);
  assign step    = (interval == '0) ? btn_rpt_pkg::CFG_W'(1) : interval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btn_rpt_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    held_nxt      = held_r;
    prior_nxt     = prior_r;
    pl_nxt        = pl_r;
    scan_nxt      = scan_r;
    b_nxt         = b_r;
    wk_nxt        = wk_r;
    res_nxt       = res_r;
    out_vld_nxt   = out_vld_r && !out_pop;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    res_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num_a = TW'(cur_x - first);
    div_req.num_b = TW'(prev_x - first);
    div_req.den   = step;
    h             = held_r[pidx];
    p             = prior_r[pidx];
    m             = q_cmd.mask;
    sel16         = '0;
    unique case (state_r)
      btn_rpt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            btn_rpt_pkg::OP_TICK: begin
              prev_nxt = cur_r;
              cur_nxt  = q_cmd.now;
            end
            btn_rpt_pkg::OP_SAMPLE: begin
              prior_nxt[pidx] = h;
              held_nxt[pidx]  = m;
              sel16           = m & ~h;
              scan_nxt        = sel16[BUTTONS-1:0];
              pl_nxt          = pidx;
              b_nxt           = '0;
              state_nxt       = btn_rpt_pkg::BK_WRITE;
            end
            btn_rpt_pkg::OP_QUERY: begin
              wk_nxt.all_held          = ((h & m) == m);
              wk_nxt.any_held          = ((h & m) != '0);
              wk_nxt.all_just_pressed  = ((h & m) == m) && ((p & m) != m);
              wk_nxt.all_just_released = ((h & m) == '0) && ((p & m) != '0);
              wk_nxt.any_just_pressed  = ((h & ~p & m) != '0);
              wk_nxt.held_buttons      = h;
              wk_nxt.previous_buttons  = p;
              wk_nxt.repeat_fire       = ((h & ~p & m) != '0);
              sel16                    = h & p & m;
              scan_nxt                 = sel16[BUTTONS-1:0];
              pl_nxt                   = pidx;
              b_nxt                    = '0;
              state_nxt = ((h & ~p & m) != '0) ? btn_rpt_pkg::BK_OUT
                                               : btn_rpt_pkg::BK_SCAN;
            end
            btn_rpt_pkg::OP_NULL_QUERY: begin
              wk_nxt    = '0;
              state_nxt = btn_rpt_pkg::BK_OUT;
            end
            default: begin
              state_nxt = btn_rpt_pkg::BK_IDLE;
            end
          endcase
        end
      end
      btn_rpt_pkg::BK_WRITE: begin
        mem_we = scan_r[b_r];
        if (b_r == LAST_B) begin
          state_nxt = btn_rpt_pkg::BK_IDLE;
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      btn_rpt_pkg::BK_SCAN: begin
        if (scan_r[b_r]) begin
          mem_re    = 1'b1;
          state_nxt = btn_rpt_pkg::BK_CHECK;
        end else if (b_r == LAST_B) begin
          state_nxt = btn_rpt_pkg::BK_OUT;
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      btn_rpt_pkg::BK_CHECK: begin
        if (cur_x < first) begin
          if (b_r == LAST_B) begin
            state_nxt = btn_rpt_pkg::BK_OUT;
          end else begin
            b_nxt     = b_r + 1'b1;
            state_nxt = btn_rpt_pkg::BK_SCAN;
          end
        end else if (prev_x < first) begin
          wk_nxt.repeat_fire = 1'b1;
          state_nxt          = btn_rpt_pkg::BK_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = btn_rpt_pkg::BK_DIV;
        end
      end
      btn_rpt_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.differ) begin
            wk_nxt.repeat_fire = 1'b1;
            state_nxt          = btn_rpt_pkg::BK_OUT;
          end else if (b_r == LAST_B) begin
            state_nxt = btn_rpt_pkg::BK_OUT;
          end else begin
            b_nxt     = b_r + 1'b1;
            state_nxt = btn_rpt_pkg::BK_SCAN;
          end
        end
      end
      btn_rpt_pkg::BK_OUT: begin
        if (!out_vld_r || out_pop) begin
          res_nxt     = wk_r;
          out_vld_nxt = 1'b1;
          res_load    = 1'b1;
          state_nxt   = btn_rpt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = btn_rpt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      prev_r    <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < PLAYERS; i++) begin
        held_r[i]  <= '0;
        prior_r[i] <= '0;
      end
      for (int j = 0; j < DEPTH; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      cur_r     <= cur_nxt;
      prev_r    <= prev_nxt;
      out_vld_r <= out_vld_nxt;
      held_r    <= held_nxt;
      prior_r   <= prior_nxt;
      if (mem_we) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pl_r   <= pl_nxt;
    scan_r <= scan_nxt;
    b_r    <= b_nxt;
    wk_r   <= wk_nxt;
    res_r  <= res_nxt;
    if (mem_re) begin
      rd_vld_r <= vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= cur_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule

[hw/rtl/button_edge_and_auto_repeat_top.sv]
// Top level of the button edge detector and auto-repeat block.
`timescale 1ns / 1ps
// Usage:
// The input channel behaves as a queue: an item is taken when push is high and
// full is low. Kind 0 is a frame tick, kind 1 a button sample, kind 2 a query.
// Only queries produce a result, which waits on the out_ ports while empty is
// low and leaves when pop is high. Ticks and samples produce nothing.
// Items enter a two-entry command queue, so the sender keeps going while a
// result waits to be popped; the back end stalls only with a result pending.
// Per item the back end latches the frame time for a tick, walks every
// button for a sample (writing the press time of each newly pressed button),
// and for a query reads the press time of each masked button held in both
// samples, adding a bit-serial divider run when both frame times lie past its
// first repeat instant. A result is registered and appears on the ports in
// the cycle after the back end loads it.
// The user writes the repeat registers through the APB-style port only while
// idle; the block does not enforce it. Reset clears frame times, masks,
// press-time valid bits and queues; delay loads 500 ms, interval 100 ms.
module button_edge_and_auto_repeat_top #(
  parameter int PLAYERS = 4,
  parameter int BUTTONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_player,
  input  logic [39:0] in_now_ms,
  input  logic [15:0] in_new_buttons,
  input  logic [15:0] in_query_mask,
  output logic        empty,
  input  logic        pop,
  output logic        out_all_held,
  output logic        out_any_held,
  output logic        out_all_just_pressed,
  output logic        out_all_just_released,
  output logic        out_any_just_pressed,
  output logic        out_repeat_fire,
  output logic [15:0] out_held_buttons,
  output logic [15:0] out_previous_buttons,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [btn_rpt_pkg::CFG_W-1:0] delay_r, interval_r;
  logic                  accept, cmd_push, q_pop, q_empty, out_vld, out_pop, res_load;
  logic                  reg_sel;
  btn_rpt_pkg::cmd_t     cmd, q_cmd;
  btn_rpt_pkg::div_req_t div_req;
  btn_rpt_pkg::div_rsp_t div_rsp;
  btn_rpt_pkg::res_t     res;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign accept  = push && !full;
  assign empty   = !out_vld;
  assign out_pop = pop && out_vld;

  assign out_all_held          = res.all_held;
  assign out_any_held          = res.any_held;
  assign out_all_just_pressed  = res.all_just_pressed;
  assign out_all_just_released = res.all_just_released;
  assign out_any_just_pressed  = res.any_just_pressed;
  assign out_repeat_fire       = res.repeat_fire;
  assign out_held_buttons      = res.held_buttons;
  assign out_previous_buttons  = res.previous_buttons;

  always_comb begin
    unique case (reg_sel)
      btn_rpt_pkg::REG_DELAY:    prdata = {16'b0, delay_r};
      btn_rpt_pkg::REG_INTERVAL: prdata = {16'b0, interval_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= btn_rpt_pkg::DELAY_RST;
      interval_r <= btn_rpt_pkg::IVL_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        btn_rpt_pkg::REG_DELAY:    delay_r    <= pwdata[15:0];
        btn_rpt_pkg::REG_INTERVAL: interval_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  btn_rpt_front #(
    .PLAYERS(PLAYERS),
    .BUTTONS(BUTTONS)
  ) u_front (
    .accept        (accept),
    .in_kind       (in_kind),
    .in_player     (in_player),
    .in_now_ms     (in_now_ms),
    .in_new_buttons(in_new_buttons),
    .in_query_mask (in_query_mask),
    .cmd_push      (cmd_push),
    .cmd           (cmd)
  );

  btn_rpt_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_data(cmd),
    .rd_en  (q_pop),
    .rd_data(q_cmd),
    .full   (full),
    .empty  (q_empty)
  );

  btn_rpt_back #(
    .PLAYERS(PLAYERS),
    .BUTTONS(BUTTONS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .delay   (delay_r),
    .interval(interval_r),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_pop (out_pop),
    .out_vld (out_vld),
    .out_res (res),
    .res_load(res_load)
  );

  btn_rpt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (empty || pop))
    else $error("result register overwritten before it was taken");

  a_res_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(res_load))
    else $error("result appeared without a load");
`endif

endmodule
